>>> sv/xor_run_length_diff_encoder_macros.svh
// Assertion macros of the XOR run-length diff encoder, used by the back part.
`ifndef XOR_RUN_LENGTH_DIFF_ENCODER_MACROS_SVH
`define XOR_RUN_LENGTH_DIFF_ENCODER_MACROS_SVH

// Check cons in the same cycle as ante.
`define XRLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xrld: same-cycle check failed");

// Check cons in the cycle after ante.
`define XRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xrld: next-cycle check failed");

`endif

>>> sv/xrld_pkg.sv
// Shared types and constants of the XOR run-length diff encoder.
package xrld_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] RUN_SPLIT = 16'h8000;
    localparam logic [15:0] RUN_MAX   = 16'hFFFF;

    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] SPLIT_BYTE = 8'hFF;

    // Output byte slots of one command, in emission order.
    localparam int SLOT_SPLIT0 = 0;
    localparam int SLOT_SPLIT1 = 1;
    localparam int SLOT_SPLIT2 = 2;
    localparam int SLOT_RUN0   = 3;
    localparam int SLOT_RUN1   = 4;
    localparam int SLOT_RUN2   = 5;
    localparam int SLOT_XOR    = 6;
    localparam int NUM_SLOTS   = 7;

    // Bit positions in the output tuser.
    localparam int USER_VALID     = 0;
    localparam int USER_ITEM_LAST = 1;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;  // slots to emit
        logic [14:0]          jm1;    // run length minus one after split
        logic [7:0]           xbyte;  // XOR byte (zero for bare marker)
        logic                 has_x;  // XOR byte is a stream byte
        logic                 last;   // item closes the stream
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

>>> sv/xrld_fifo.sv
// Short command queue between the front and back parts.
module xrld_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output xrld_pkg::t_q_stat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data          = r_mem[r_rd_ptr];
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.nonempty = (r_count != '0);

endmodule

>>> sv/xrld_front.sv
// Front part: XOR, zero-run tracking and command classification.
module xrld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_cur,
    input  logic [7:0]         i_prev,
    input  logic               i_last,
    input  logic               i_q_full,
    output logic               o_push,
    output xrld_pkg::t_cmd     o_cmd
);

    logic [15:0] r_zero_run, n_zero_run;
    logic [7:0]  x;
    logic        x_nz;
    logic        accept;
    logic        split;
    logic [15:0] rem;
    logic        run_nz;
    logic [15:0] jm1_w;
    logic        long_run;

    always_comb begin
        x        = i_cur ^ i_prev;
        x_nz     = |x;
        accept   = i_valid && !i_q_full;
        split    = r_zero_run > xrld_pkg::RUN_SPLIT;
        rem      = split ? r_zero_run - xrld_pkg::RUN_SPLIT : r_zero_run;
        run_nz   = |rem;
        jm1_w    = rem - 16'd1;
        long_run = run_nz && (jm1_w[14:7] != 8'd0);

        o_cmd.slots = {1'b1, x_nz && long_run, x_nz && run_nz, x_nz && run_nz,
                       {3{x_nz && split}}};
        o_cmd.jm1   = jm1_w[14:0];
        o_cmd.xbyte = x;
        o_cmd.has_x = x_nz;
        o_cmd.last  = i_last;

        // Items that only extend a run produce no command.
        o_push = accept && (x_nz || i_last);

        n_zero_run = r_zero_run;
        if (accept) begin
            if (x_nz || i_last) begin
                n_zero_run = '0;
            end else if (r_zero_run != xrld_pkg::RUN_MAX) begin
                n_zero_run = r_zero_run + 16'd1;
            end
        end
    end

    assign o_ready = !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
        end else begin
            r_zero_run <= n_zero_run;
        end
    end

endmodule

>>> sv/xrld_back.sv
// Back part: expands queued commands into output bytes, one per cycle unless the output stalls.
`include "xor_run_length_diff_encoder_macros.svh"

module xrld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  xrld_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_data,
    output logic [1:0]         o_user,
    output logic               o_last
);

    logic                          r_busy, n_busy;
    logic [xrld_pkg::NUM_SLOTS-1:0] r_slots, n_slots;
    xrld_pkg::t_cmd                r_cmd;
    logic                          r_ovalid;
    logic [7:0]                    r_obyte;
    logic [1:0]                    r_ouser;
    logic                          r_olast;

    logic                          adv;
    logic                          emit;
    logic [xrld_pkg::NUM_SLOTS-1:0] low;
    logic [xrld_pkg::NUM_SLOTS-1:0] rest;
    logic                          done;
    logic [7:0]                    e_byte;
    logic                          e_valid;
    logic                          e_end;

    always_comb begin
        adv   = !r_ovalid || i_ready;
        emit  = adv && r_busy;
        low   = r_slots & (~r_slots + 1'b1);
        rest  = r_slots & ~low;
        done  = (rest == '0);
        o_pop = i_q_valid && (!r_busy || (emit && done));

        e_valid = 1'b1;
        e_end   = 1'b0;
        priority if (r_slots[xrld_pkg::SLOT_SPLIT0]) begin
            e_byte = xrld_pkg::ZERO_BYTE;
        end else if (r_slots[xrld_pkg::SLOT_SPLIT1]) begin
            e_byte = xrld_pkg::SPLIT_BYTE;
        end else if (r_slots[xrld_pkg::SLOT_SPLIT2]) begin
            e_byte = xrld_pkg::SPLIT_BYTE;
        end else if (r_slots[xrld_pkg::SLOT_RUN0]) begin
            e_byte = xrld_pkg::ZERO_BYTE;
        end else if (r_slots[xrld_pkg::SLOT_RUN1]) begin
            // Set bit 7 when a high byte follows.
            e_byte = {r_slots[xrld_pkg::SLOT_RUN2], r_cmd.jm1[6:0]};
        end else if (r_slots[xrld_pkg::SLOT_RUN2]) begin
            e_byte = r_cmd.jm1[14:7];
        end else begin
            e_byte  = r_cmd.xbyte;
            e_valid = r_cmd.has_x;
            e_end   = r_cmd.last;
        end

        n_busy  = r_busy;
        n_slots = r_slots;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_slots = i_cmd.slots;
        end else if (emit) begin
            n_busy  = !done;
            n_slots = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_slots  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_slots <= n_slots;
            if (adv) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_obyte                           <= e_byte;
            r_ouser[xrld_pkg::USER_VALID]     <= e_valid;
            r_ouser[xrld_pkg::USER_ITEM_LAST] <= done;
            r_olast                           <= e_end;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_obyte;
    assign o_user  = r_ouser;
    assign o_last  = r_olast;

    `XRLD_ASSERT_SAME(a_end_is_item_last, i_clk, i_rst_n, r_ovalid && r_olast, r_ouser[xrld_pkg::USER_ITEM_LAST])
    `XRLD_ASSERT_SAME(a_marker_ends_stream, i_clk, i_rst_n, r_ovalid && !r_ouser[xrld_pkg::USER_VALID], r_olast)
    `XRLD_ASSERT_SAME(a_busy_has_xor_slot, i_clk, i_rst_n, r_busy, r_slots[xrld_pkg::SLOT_XOR])
    `XRLD_ASSERT_NEXT(a_idle_after_drain, i_clk, i_rst_n, emit && done && !i_q_valid, !r_busy)

endmodule

>>> sv/xor_run_length_diff_encoder.sv
// Path of a command item: command queue, slot register, then the output register.
// Throughput: one input transfer per cycle while the command queue has room;
// one output byte per cycle while the output is not stalled; an item yields 1 to 7 bytes.
// Items that only extend a zero run produce no output byte; the queue depth sets the slack.
// Reset (i_rst_n low at a clock edge) clears the zero run, the queue, back state and tvalid.
// When the last byte of an image is accepted, the zero run is cleared for the next stream.
module xor_run_length_diff_encoder #(
    parameter int QUEUE_DEPTH = xrld_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] cur_byte, [15:8] prev_byte
    input  logic        i_s_tlast,   // last_byte
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [1:0]  o_m_tuser,   // [0] out_valid, [1] item_last
    output logic        o_m_tlast    // stream_end
);

    localparam int CMD_W = $bits(xrld_pkg::t_cmd);

    xrld_pkg::t_cmd    push_cmd;
    xrld_pkg::t_cmd    head_cmd;
    xrld_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;
    logic [CMD_W-1:0]  head_bits;

    // Front: XOR each byte pair, count zero runs, push one command per
    // nonzero XOR or end of image.
    xrld_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_cur    (i_s_tdata[7:0]),
        .i_prev   (i_s_tdata[15:8]),
        .i_last   (i_s_tlast),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Queue decouples input acceptance from multi-byte emission.
    xrld_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_stat  (q_stat)
    );

    assign head_cmd = xrld_pkg::t_cmd'(head_bits);

    // Back: walk the slots of each command and drive the output register.
    xrld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_stat.nonempty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_user    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule
